@@ sv/quoted_literal_unescaper_top_defines.svh @@
// Assertion macros shared by the quoted literal unescaper RTL.
`ifndef QUOTED_LITERAL_UNESCAPER_TOP_DEFINES_SVH
`define QUOTED_LITERAL_UNESCAPER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define QLU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qlu: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define QLU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qlu: next-cycle check failed");

`endif

@@ sv/qlu_pkg.sv @@
// Types, codes and the escape decode for the quoted literal unescaper.
package qlu_pkg;

    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;
    localparam int LENGTH_BITS = 16;

    typedef logic [LINE_BITS-1:0]   line_t;
    typedef logic [COLUMN_BITS-1:0] column_t;
    typedef logic [LENGTH_BITS-1:0] length_t;
    typedef logic [7:0]             char_t;
    typedef logic [2:0]             mode_t;
    typedef logic [2:0]             err_t;
    typedef logic [1:0]             op_t;

    localparam op_t OP_CONSUME   = 2'd0;
    localparam op_t OP_BEGIN_STR = 2'd1;
    localparam op_t OP_BEGIN_CHR = 2'd2;

    localparam mode_t M_IDLE      = 3'd0;
    localparam mode_t M_STR       = 3'd1;
    localparam mode_t M_STR_ESC   = 3'd2;
    localparam mode_t M_CHR_FIRST = 3'd3;
    localparam mode_t M_CHR_ESC   = 3'd4;
    localparam mode_t M_CHR_CLOSE = 3'd5;

    localparam err_t E_NONE     = 3'd0;
    localparam err_t E_ESCAPE   = 3'd1;
    localparam err_t E_UNCLOSED = 3'd2;
    localparam err_t E_LONE     = 3'd3;
    localparam err_t E_CHAR     = 3'd4;

    localparam char_t CH_NUL   = 8'h00;
    localparam char_t CH_BS    = 8'h08;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_LF    = 8'h0A;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_DQUOTE = 8'h22;
    localparam char_t CH_SQUOTE = 8'h27;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_BSLASH = 8'h5C;
    localparam char_t CH_LOW_B = 8'h62;
    localparam char_t CH_LOW_N = 8'h6E;
    localparam char_t CH_LOW_R = 8'h72;
    localparam char_t CH_LOW_T = 8'h74;

    typedef struct packed {
        logic  ok;
        char_t value;
    } esc_t;

    function automatic esc_t unescape(input char_t c);
        esc_t r;
        r.ok    = 1'b1;
        r.value = c;
        case (c)
            CH_BSLASH, CH_SQUOTE, CH_DQUOTE: r.value = c;
            CH_LOW_B: r.value = CH_BS;
            CH_LOW_T: r.value = CH_TAB;
            CH_LOW_R: r.value = CH_CR;
            CH_LOW_N: r.value = CH_LF;
            CH_ZERO:  r.value = CH_NUL;
            default:
            begin
                r.ok    = 1'b0;
                r.value = CH_NUL;
            end
        endcase
        return r;
    endfunction

endpackage

@@ sv/quoted_literal_unescaper_top.sv @@
// Quoted literal unescaper: position tracking and string/char literal decode.
// One beat in, one beat out, at up to one beat per clock while the output is not
// stalled. A beat passes an input register and then a result register, where its
// result is presented; a stall holds it in either register.
// The mode, line, column and length registers update as a beat moves from the
// input register into the result register; that single update is the loop that
// sets the rate.
`include "quoted_literal_unescaper_top_defines.svh"

module quoted_literal_unescaper_top
    import qlu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  op_t     op,
    input  char_t   ch,
    input  logic    at_end,
    output logic    out_valid,
    input  logic    out_stall,
    output char_t   byte_out,
    output logic    byte_valid,
    output logic    literal_done,
    output err_t    error_code,
    output line_t   line_now,
    output column_t column_now,
    output length_t literal_length
);

    logic    s_valid_reg;
    op_t     s_op_reg;
    char_t   s_ch_reg;
    logic    s_end_reg;

    mode_t   mode_reg, mode_next;
    line_t   line_reg, line_next;
    column_t column_reg, column_next;
    length_t length_reg, length_next;
    char_t   held_reg, held_next;

    logic    o_valid_reg;
    char_t   o_byte_reg, o_byte_next;
    logic    o_bvalid_reg, o_bvalid_next;
    logic    o_done_reg, o_done_next;
    err_t    o_err_reg, o_err_next;

    logic    advance;
    char_t   c;
    esc_t    esc;

    assign advance  = !o_valid_reg || !out_stall;
    assign in_stall = s_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s_op_reg  <= op;
            s_ch_reg  <= ch;
            s_end_reg <= at_end;
        end
    end

    assign c   = s_end_reg ? CH_NUL : s_ch_reg;
    assign esc = unescape(c);

    always_comb
    begin
        mode_next     = mode_reg;
        line_next     = line_reg;
        column_next   = column_reg;
        length_next   = length_reg;
        held_next     = held_reg;
        o_byte_next   = CH_NUL;
        o_bvalid_next = 1'b0;
        o_done_next   = 1'b0;
        o_err_next    = E_NONE;

        if (s_op_reg == OP_BEGIN_STR || s_op_reg == OP_BEGIN_CHR)
        begin
            mode_next   = (s_op_reg == OP_BEGIN_STR) ? M_STR : M_CHR_FIRST;
            length_next = '0;
        end
        else if (s_op_reg == OP_CONSUME)
        begin
            if (!s_end_reg)
            begin
                if (c == CH_LF)
                begin
                    if (line_reg != '1)
                    begin
                        line_next = line_reg + line_t'(1);
                    end
                    column_next = column_t'(1);
                end
                else if (column_reg != '1)
                begin
                    column_next = column_reg + column_t'(1);
                end
            end

            case (mode_reg)
                M_IDLE:
                begin
                    mode_next = M_IDLE;
                end
                M_STR:
                begin
                    if (c == CH_DQUOTE)
                    begin
                        o_done_next = 1'b1;
                        mode_next   = M_IDLE;
                    end
                    else if (c inside {CH_LF, CH_NUL})
                    begin
                        o_err_next = (length_reg == '0) ? E_LONE : E_UNCLOSED;
                        mode_next  = M_IDLE;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        mode_next = M_STR_ESC;
                    end
                    else
                    begin
                        o_byte_next   = c;
                        o_bvalid_next = 1'b1;
                        if (length_reg != '1)
                        begin
                            length_next = length_reg + length_t'(1);
                        end
                    end
                end
                M_STR_ESC:
                begin
                    if (!s_end_reg && esc.ok)
                    begin
                        o_byte_next   = esc.value;
                        o_bvalid_next = 1'b1;
                        if (length_reg != '1)
                        begin
                            length_next = length_reg + length_t'(1);
                        end
                        mode_next = M_STR;
                    end
                    else
                    begin
                        o_err_next = E_ESCAPE;
                        mode_next  = M_IDLE;
                    end
                end
                M_CHR_FIRST:
                begin
                    if (s_end_reg)
                    begin
                        o_err_next = E_CHAR;
                        mode_next  = M_IDLE;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        mode_next = M_CHR_ESC;
                    end
                    else
                    begin
                        held_next = c;
                        mode_next = M_CHR_CLOSE;
                    end
                end
                M_CHR_ESC:
                begin
                    if (!s_end_reg && esc.ok)
                    begin
                        held_next = esc.value;
                        mode_next = M_CHR_CLOSE;
                    end
                    else
                    begin
                        o_err_next = E_ESCAPE;
                        mode_next  = M_IDLE;
                    end
                end
                M_CHR_CLOSE:
                begin
                    if (!s_end_reg && c == CH_SQUOTE)
                    begin
                        o_byte_next   = held_reg;
                        o_bvalid_next = 1'b1;
                        o_done_next   = 1'b1;
                        length_next   = length_t'(1);
                    end
                    else
                    begin
                        o_err_next = E_CHAR;
                    end
                    mode_next = M_IDLE;
                end
                default:
                begin
                    mode_next = M_IDLE;
                end
            endcase
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            mode_reg    <= M_IDLE;
            line_reg    <= line_t'(1);
            column_reg  <= column_t'(1);
            length_reg  <= '0;
            held_reg    <= '0;
        end
        else if (advance)
        begin
            o_valid_reg <= s_valid_reg;
            if (s_valid_reg)
            begin
                mode_reg   <= mode_next;
                line_reg   <= line_next;
                column_reg <= column_next;
                length_reg <= length_next;
                held_reg   <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s_valid_reg)
        begin
            o_byte_reg   <= o_byte_next;
            o_bvalid_reg <= o_bvalid_next;
            o_done_reg   <= o_done_next;
            o_err_reg    <= o_err_next;
        end
    end

    assign out_valid      = o_valid_reg;
    assign byte_out       = o_byte_reg;
    assign byte_valid     = o_bvalid_reg;
    assign literal_done   = o_done_reg;
    assign error_code     = o_err_reg;
    assign line_now       = line_reg;
    assign column_now     = column_reg;
    assign literal_length = length_reg;

    // an error beat carries neither a byte nor done
    `QLU_ASSERT_NOW(a_err_excl, o_valid_reg && o_err_reg != E_NONE, !o_bvalid_reg && !o_done_reg)
    // position never drops to zero
    `QLU_ASSERT_NOW(a_pos_nonzero, 1'b1, line_reg != '0 && column_reg != '0)
    // a held input beat leaves the position untouched
    `QLU_ASSERT_NEXT(a_hold_pos, s_valid_reg && !advance, $stable(line_reg) && $stable(column_reg))
    // done on a byte beat only comes from a char literal, whose length is one
    `QLU_ASSERT_NOW(a_chr_len, o_valid_reg && o_done_reg && o_bvalid_reg,
        length_reg == length_t'(1))

endmodule
